// ----- src/dfc_pkg.sv -----
// Shared constants and types for the decimal formatter with group commas.
package dfc_pkg;
   localparam int VALUE_W         = 64;
   localparam int DIGITS          = 20;
   localparam int BCD_W           = 4 * DIGITS;
   localparam int STEPS_PER_STAGE = 8;
   localparam int NUM_STAGES      = VALUE_W / STEPS_PER_STAGE;
   localparam int IDX_W           = $clog2(DIGITS);
   localparam int CHAR_W          = 7;
   localparam int BUF_W           = 10;
   localparam logic [BUF_W-1:0]  BUF_RESET   = 10'd1000;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_COMMA  = 7'h2c;
   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'h2d;
   localparam logic [CHAR_W-1:0] CHAR_NONE   = 7'h00;
   localparam logic              STATUS_OK   = 1'b0;
   localparam logic              STATUS_SMALL = 1'b1;

   typedef logic [3:0] digit_type;
endpackage

// ----- src/dfc_if.sv -----
// Channel interfaces: request word, response word and register write.
interface dfc_req_if import dfc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface dfc_rsp_if import dfc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;
   logic              status;
   modport source (output valid, output char_code, output last, output status, input ready);
   modport sink   (input valid, input char_code, input last, input status, output ready);
endinterface

interface dfc_csr_if import dfc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [BUF_W-1:0] buffer_size;
   modport source (output valid, output buffer_size, input ready);
   modport sink   (input valid, input buffer_size, output ready);
endinterface

// ----- src/dfc_bcd_stage.sv -----
// One pipeline stage of shift-and-add-3 binary to BCD conversion.
module dfc_bcd_stage import dfc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               valid_i,
   input  logic [VALUE_W-1:0] bin_i,
   input  logic [BCD_W-1:0]   bcd_i,
   input  logic               neg_i,
   output logic               valid_o,
   output logic [VALUE_W-1:0] bin_o,
   output logic [BCD_W-1:0]   bcd_o,
   output logic               neg_o
);
   logic               valid_ff;
   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic               neg_ff;

   // a fixed slice of the conversion steps
   always_comb begin
      logic [BCD_W+VALUE_W-1:0] t;
      bin_in = bin_i;
      bcd_in = bcd_i;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
         for (int k = 0; k < DIGITS; k++) begin
            if (bcd_in[4*k +: 4] >= 4'd5) bcd_in[4*k +: 4] = bcd_in[4*k +: 4] + 4'd3;
         end
         t = {bcd_in, bin_in} << 1;
         bcd_in = t[BCD_W+VALUE_W-1:VALUE_W];
         bin_in = t[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
      if (en) begin
         bin_ff <= bin_in;
         bcd_ff <= bcd_in;
         neg_ff <= neg_i;
      end
   end

   assign valid_o = valid_ff;
   assign bin_o   = bin_ff;
   assign bcd_o   = bcd_ff;
   assign neg_o   = neg_ff;
endmodule

// ----- src/dfc_emit.sv -----
// Serializer: length check, then either a single status word or sign, digits and commas, one word per character.
module dfc_emit import dfc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             valid_i,
   input  logic [BCD_W-1:0] bcd_i,
   input  logic             neg_i,
   input  logic [BUF_W-1:0] buffer_size,
   output logic             ready_o,
   dfc_rsp_if.source        rsp
);
   typedef enum logic [2:0] {IDLE, CHECK, SIGN, DIGIT, COMMA, SMALL} state_type;

   state_type         state_ff;
   digit_type         dig_ff [DIGITS];
   logic              neg_ff;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;   // digit count minus one
   logic [IDX_W-1:0]  idx_ff;
   logic [1:0]        grp_ff;
   logic              rvalid_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              last_ff, status_ff;
   logic              out_free;
   logic              word_go;
   logic [IDX_W-1:0]  div3;
   logic [1:0]        mod3;
   logic [9:0]        prod;
   logic [5:0]        needed;

   // index of the top nonzero digit (zero formats as one digit)
   always_comb begin
      cnt_in = '0;
      for (int k = 0; k < DIGITS; k++) begin
         if (bcd_i[4*k +: 4] != 4'd0) cnt_in = IDX_W'(k);
      end
   end

   // (count-1)/3 by reciprocal, valid for count up to twenty
   assign prod   = 10'(cnt_ff) * 10'd11;
   assign div3   = IDX_W'(prod[9:5]);
   assign mod3   = 2'(cnt_ff - IDX_W'(div3 * 3));
   assign needed = 6'(cnt_ff) + 6'd1 + 6'(div3) + 6'(neg_ff);

   assign out_free = !rvalid_ff || rsp.ready;
   assign ready_o  = (state_ff == IDLE);

   // a new word is loaded into the output register this cycle
   assign word_go = out_free && (state_ff == SMALL || state_ff == SIGN ||
                                 state_ff == DIGIT || state_ff == COMMA);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= word_go || (rvalid_ff && !rsp.ready);
         case (state_ff)
            IDLE: begin
               if (valid_i) begin
                  for (int k = 0; k < DIGITS; k++) dig_ff[k] <= bcd_i[4*k +: 4];
                  neg_ff   <= neg_i;
                  cnt_ff   <= cnt_in;
                  state_ff <= CHECK;
               end
            end
            CHECK: begin
               idx_ff <= cnt_ff;
               grp_ff <= mod3;
               if (buffer_size <= 10'(needed)) state_ff <= SMALL;
               else if (neg_ff)                 state_ff <= SIGN;
               else                             state_ff <= DIGIT;
            end
            SMALL: begin
               if (out_free) begin
                  char_ff   <= CHAR_NONE;
                  last_ff   <= 1'b1;
                  status_ff <= STATUS_SMALL;
                  state_ff  <= IDLE;
               end
            end
            SIGN: begin
               if (out_free) begin
                  char_ff   <= CHAR_MINUS;
                  last_ff   <= 1'b0;
                  status_ff <= STATUS_OK;
                  state_ff  <= DIGIT;
               end
            end
            DIGIT: begin
               if (out_free) begin
                  char_ff   <= CHAR_ZERO + CHAR_W'(dig_ff[idx_ff]);
                  last_ff   <= (idx_ff == '0);
                  status_ff <= STATUS_OK;
                  if (idx_ff == '0) begin
                     state_ff <= IDLE;
                  end else if (grp_ff == 2'd0) begin
                     state_ff <= COMMA;
                  end else begin
                     idx_ff <= idx_ff - 1'b1;
                     grp_ff <= grp_ff - 1'b1;
                  end
               end
            end
            COMMA: begin
               if (out_free) begin
                  char_ff   <= CHAR_COMMA;
                  last_ff   <= 1'b0;
                  status_ff <= STATUS_OK;
                  idx_ff    <= idx_ff - 1'b1;
                  grp_ff    <= 2'd2;
                  state_ff  <= DIGIT;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp.valid     = rvalid_ff;
   assign rsp.char_code = char_ff;
   assign rsp.last      = last_ff;
   assign rsp.status    = status_ff;
endmodule

// ----- src/decimal_format_with_group_commas.sv -----
// Top level of the decimal formatter with thousands separators.
// Each request word carries a signed 64-bit value; the block returns its decimal text one ASCII
// character per response word: an optional '-', then digits from most significant, with ','
// between groups of three, last set on the final character. If buffer_size is at most the text
// length, a single word with status 1, char_code 0 and last 1 comes instead. The value passes a
// negate register and eight conversion stages of eight shift-add-3 steps each (a new word may
// enter every cycle while the last stage is empty or the serializer is idle); the serializer
// then captures the item, checks its length and emits one word per character, holding while
// the response side has not taken the previous word.
// buffer_size resets to 1000 and should be written only while the block is idle.
module decimal_format_with_group_commas import dfc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dfc_req_if.sink   req,
   dfc_rsp_if.source rsp,
   dfc_csr_if.sink   csr
);
   logic [BUF_W-1:0]   buf_ff;
   logic               en;
   logic               emit_ready;
   logic               v   [NUM_STAGES+1];
   logic [VALUE_W-1:0] bin [NUM_STAGES+1];
   logic [BCD_W-1:0]   bcd [NUM_STAGES+1];
   logic               neg [NUM_STAGES+1];
   logic               v0_ff, neg0_ff;
   logic [VALUE_W-1:0] mag0_ff;

   // configuration register
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= BUF_RESET;
      end else if (csr.valid) begin
         buf_ff <= csr.buffer_size;
      end
   end

   // whole pipeline moves when its tail is empty or drained
   assign en        = !v[NUM_STAGES] || emit_ready;
   assign req.ready = en;

   // front stage: sign and magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req.valid;
      end
      if (en) begin
         neg0_ff <= req.value[VALUE_W-1];
         mag0_ff <= req.value[VALUE_W-1] ? (~req.value + 1'b1) : req.value;
      end
   end

   assign v[0]   = v0_ff;
   assign bin[0] = mag0_ff;
   assign bcd[0] = '0;
   assign neg[0] = neg0_ff;

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
      dfc_bcd_stage u_stage (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .valid_i (v[g]),
         .bin_i   (bin[g]),
         .bcd_i   (bcd[g]),
         .neg_i   (neg[g]),
         .valid_o (v[g+1]),
         .bin_o   (bin[g+1]),
         .bcd_o   (bcd[g+1]),
         .neg_o   (neg[g+1])
      );
   end

   dfc_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .valid_i     (v[NUM_STAGES]),
      .bcd_i       (bcd[NUM_STAGES]),
      .neg_i       (neg[NUM_STAGES]),
      .buffer_size (buf_ff),
      .ready_o     (emit_ready),
      .rsp         (rsp)
   );
endmodule

// ----- test/tb_dfc_if.sv -----
// Testbench-side instances are built from the RTL interfaces; this file holds the scoreboard class.
package tb_dfc_sb_pkg;
   import dfc_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
      logic              status;
   } char_word_type;

   class text_scoreboard;
      char_word_type    pending[$];
      logic [BUF_W-1:0] buf_size;
      int               errors;

      function new();
         buf_size = BUF_RESET;
         errors   = 0;
      endfunction

      // Build the expected characters for one accepted value
      function void note_value(logic signed [VALUE_W-1:0] v);
         logic [VALUE_W-1:0] mag;
         digit_type          dig[DIGITS];
         int                 n, need;
         char_word_type      w;
         mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
         n = 0;
         do begin
            dig[n] = digit_type'(mag % 10);
            mag    = mag / 10;
            n++;
         end while (mag != 0);
         need = n + (n - 1) / 3 + (v[VALUE_W-1] ? 1 : 0);
         if (buf_size <= need) begin
            w.char_code = CHAR_NONE; w.last = 1'b1; w.status = STATUS_SMALL;
            pending.push_back(w);
            return;
         end
         w.last = 1'b0; w.status = STATUS_OK;
         if (v[VALUE_W-1]) begin
            w.char_code = CHAR_MINUS;
            pending.push_back(w);
         end
         for (int i = n - 1; i >= 0; i--) begin
            w.char_code = CHAR_ZERO + dig[i];
            w.last = (i == 0);
            pending.push_back(w);
            if (i > 0 && i % 3 == 0) begin
               w.char_code = CHAR_COMMA; w.last = 1'b0;
               pending.push_back(w);
            end
         end
      endfunction

      // Compare one response word with the oldest expectation
      task check_char(char_word_type got);
         char_word_type exp_w;
         if (pending.size() == 0) begin
            report_err($sformatf("unexpected word %h", got));
            return;
         end
         exp_w = pending.pop_front();
         if (got.char_code !== exp_w.char_code)
            report_err($sformatf("char_code %h, want %h", got.char_code, exp_w.char_code));
         if (got.last !== exp_w.last)
            report_err($sformatf("last %b, want %b", got.last, exp_w.last));
         if (got.status !== exp_w.status)
            report_err($sformatf("status %b, want %b", got.status, exp_w.status));
      endtask

      task report_err(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask
   endclass
endpackage

// ----- test/tb_top.sv -----
// Top-level testbench for the decimal formatter: directed and random traffic checked against a predictor.
module tb_top;
   import dfc_pkg::*;
   import tb_dfc_sb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   idle_cycles = 0;
   bit   rsp_stall_on = 1'b1;

   dfc_req_if req ();
   dfc_rsp_if rsp ();
   dfc_csr_if csr ();

   text_scoreboard sb = new();

   decimal_format_with_group_commas i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // valid stays high after the accept edge until the next send or an explicit drop
   task automatic send_value(logic signed [VALUE_W-1:0] v);
      int gap;
      gap = gap_len();
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.value <= v;
      do @(posedge clock); while (!req.ready);
      sb.note_value(v);
      @(negedge clock);
   endtask

   task automatic write_buf_size(logic [BUF_W-1:0] sz);
      req.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr.valid       <= 1'b1;
      csr.buffer_size <= sz;
      do @(posedge clock); while (!csr.ready);
      sb.buf_size = sz;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   function automatic logic [VALUE_W-1:0] rand_value();
      logic [VALUE_W-1:0] v;
      v = {$urandom(), $urandom()};
      // Vary the magnitude so every digit count shows up
      case ($urandom_range(0, 3))
         0: v = v >> $urandom_range(0, 63);
         1: v = -(v >> $urandom_range(0, 63));
         default: ;
      endcase
      return v;
   endfunction

   // Response side: random stalls while rsp_stall_on is set, sample at rising edge
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= rsp_stall_on ? (gap_len() == 0) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_char('{rsp.char_code, rsp.last, rsp.status});
   end

   // Watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic signed [VALUE_W-1:0] directed[$];
      int sizes[$];
      req.valid = 1'b0;
      req.value = '0;
      csr.valid = 1'b0;
      csr.buffer_size = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed = '{0, 1, -1, 9, 10, 999, 1000, -1000, 123456, -999999, 1000000,
                   64'sh7fffffffffffffff, 64'sh8000000000000000, 64'sh8000000000000001,
                   64'shffffffffffffffff, 64'sh5555555555555555, 64'shaaaaaaaaaaaaaaaa};
      foreach (directed[i]) send_value(directed[i]);

      // Zero, tight and large sizes around the overflow boundary
      sizes = '{0, 1, 2, 26, 27, 5, 1023};
      foreach (sizes[s]) begin
         write_buf_size(BUF_W'(sizes[s]));
         send_value(0);
         send_value(-1000);
         send_value(1234);
         send_value(64'sh8000000000000000);
      end

      write_buf_size(BUF_W'($urandom_range(0, 1023)));
      for (int i = 0; i < 125; i++) begin
         if (i % 40 == 39) write_buf_size($urandom_range(0, 3) == 0 ?
                                          BUF_W'($urandom_range(0, 1023)) :
                                          BUF_W'($urandom_range(2, 28)));
         if (i == 70) rsp_stall_on = 1'b0;
         if (i == 100) rsp_stall_on = 1'b1;
         send_value(rand_value());
      end
      req.valid <= 1'b0;

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
